>>> rtl/core/fds_pkg.sv
// Shared types, constants and datapath operation codes of the formation distance stress block.
package fds_pkg;

  localparam int MAX_AGENTS_DEF = 16;
  localparam int COORD_W        = 24;
  localparam int SCALE_W        = 24;
  localparam int STRESS_W       = 63;
  localparam int AGENT_COUNT_W  = 5;
  localparam int NUM_COORDS     = 6;
  localparam int SCL_COORD_W    = 25;
  localparam int SUMSQ_W        = 52;
  localparam int ROOT_W         = 26;
  localparam int SQRT_STEPS     = 26;
  localparam int PADDR_W        = 3;
  localparam logic [SCALE_W-1:0] INV_SCALE_RESET = 24'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [COORD_W-1:0] goal_z;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [STRESS_W-1:0]      stress;
    logic [AGENT_COUNT_W-1:0] agent_count;
    logic                     saturated;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_SMUL,
    OP_SCLAMP,
    OP_SWRITE,
    OP_LATA,
    OP_LATB,
    OP_QMUL,
    OP_QACC,
    OP_RINIT,
    OP_RSTEP,
    OP_RSAVE,
    OP_TMUL,
    OP_TADD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] coord;
    logic       sel;
    logic       store;
    logic       ovf;
  } ctrl_t;

endpackage

>>> rtl/core/fds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/fds_dp.sv
// Datapath: agent stores, shared multiplier, square root unit and stress accumulator.
module fds_dp #(
  parameter int MAX_AGENTS = fds_pkg::MAX_AGENTS_DEF
) (
  input  logic                                clk,
  input  fds_pkg::item_t                      item,
  input  logic [fds_pkg::SCALE_W-1:0]         inv_scale,
  input  fds_pkg::ctrl_t                      ctl,
  input  logic [$clog2(MAX_AGENTS)-1:0]       raw_waddr,
  input  logic [$clog2(MAX_AGENTS)-1:0]       raw_raddr,
  input  logic [$clog2(MAX_AGENTS)-1:0]       scl_waddr,
  input  logic [$clog2(MAX_AGENTS)-1:0]       scl_raddr,
  input  logic [$clog2(MAX_AGENTS+1)-1:0]     n,
  output fds_pkg::result_t                    result
);

  localparam int RAW_W = fds_pkg::NUM_COORDS * fds_pkg::COORD_W;
  localparam int SCW   = fds_pkg::SCL_COORD_W;
  localparam int SCL_W = fds_pkg::NUM_COORDS * SCW;
  localparam int SQW   = fds_pkg::SUMSQ_W;
  localparam int RW    = fds_pkg::ROOT_W;

  logic [RAW_W-1:0] raw_wdata, raw_rdata;
  logic [SCL_W-1:0] scl_wdata, scl_rdata;

  logic signed [fds_pkg::COORD_W-1:0] rc [fds_pkg::NUM_COORDS];
  logic signed [SCW-1:0] sc [fds_pkg::NUM_COORDS];
  logic signed [SCW-1:0] sr [fds_pkg::NUM_COORDS];
  logic signed [SCW-1:0] a_hold [fds_pkg::NUM_COORDS];
  logic signed [SCW-1:0] b_hold [fds_pkg::NUM_COORDS];

  logic [fds_pkg::SCALE_W-1:0] inv_l;
  logic signed [27:0] ma, mb;
  logic signed [55:0] prod;
  logic signed [47:0] q;
  logic signed [SCW:0] d;
  logic [SCW:0] absd;
  logic [SQW-1:0] sum_c, sum_g;
  logic [SQW-1:0] x, r, bitv;
  logic [SQW:0] trial;
  logic [RW-1:0] dc, dg, tdiff;
  logic [fds_pkg::STRESS_W-1:0] stress;
  logic [fds_pkg::STRESS_W:0] tsum;
  logic sat;

  assign raw_wdata = {item.pos_x, item.pos_y, item.pos_z, item.goal_x, item.goal_y, item.goal_z};

  always_comb begin
    for (int c = 0; c < fds_pkg::NUM_COORDS; c++) begin
      rc[c] = raw_rdata[(fds_pkg::NUM_COORDS-1-c)*fds_pkg::COORD_W +: fds_pkg::COORD_W];
      sr[c] = scl_rdata[(fds_pkg::NUM_COORDS-1-c)*SCW +: SCW];
      scl_wdata[(fds_pkg::NUM_COORDS-1-c)*SCW +: SCW] = sc[c];
    end
  end

  fds_ram #(.WIDTH(RAW_W), .DEPTH(MAX_AGENTS)) u_raw (
    .clk(clk), .we(ctl.store), .waddr(raw_waddr), .wdata(raw_wdata),
    .raddr(raw_raddr), .rdata(raw_rdata)
  );

  fds_ram #(.WIDTH(SCL_W), .DEPTH(MAX_AGENTS)) u_scl (
    .clk(clk), .we(ctl.op == fds_pkg::OP_SWRITE), .waddr(scl_waddr), .wdata(scl_wdata),
    .raddr(scl_raddr), .rdata(scl_rdata)
  );

  // Operand selection for the one shared multiplier.
  always_comb begin
    d     = {a_hold[ctl.coord][SCW-1], a_hold[ctl.coord]} -
            {b_hold[ctl.coord][SCW-1], b_hold[ctl.coord]};
    absd  = d[SCW] ? (SCW+1)'(-d) : d;
    tdiff = (dc > dg) ? (dc - dg) : (dg - dc);
    q     = prod[55:8];
    trial = {1'b0, r} + {1'b0, bitv};
    tsum  = {1'b0, stress} + {12'b0, prod[51:0]};
    case (ctl.op)
      fds_pkg::OP_SMUL: begin
        ma = {{4{rc[ctl.coord][fds_pkg::COORD_W-1]}}, rc[ctl.coord]};
        mb = {4'b0, inv_l};
      end
      fds_pkg::OP_QMUL: begin
        ma = {2'b0, absd};
        mb = {2'b0, absd};
      end
      fds_pkg::OP_TMUL: begin
        ma = {2'b0, tdiff};
        mb = {2'b0, tdiff};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (ctl.op)
      fds_pkg::OP_START: begin
        inv_l  <= inv_scale;
        stress <= '0;
        sat    <= 1'b0;
      end
      fds_pkg::OP_SCLAMP: begin
        if (q > 48'sd16777215) begin
          sc[ctl.coord] <= 25'sh0FFFFFF;
          sat <= 1'b1;
        end else if (q < -48'sd16777216) begin
          sc[ctl.coord] <= 25'sh1000000;
          sat <= 1'b1;
        end else begin
          sc[ctl.coord] <= q[SCW-1:0];
        end
      end
      fds_pkg::OP_LATA: a_hold <= sr;
      fds_pkg::OP_LATB: b_hold <= sr;
      fds_pkg::OP_QACC: begin
        if (ctl.coord < 3'd3) begin
          sum_c <= ((ctl.coord == 3'd0) ? '0 : sum_c) + prod[SQW-1:0];
        end else begin
          sum_g <= ((ctl.coord == 3'd3) ? '0 : sum_g) + prod[SQW-1:0];
        end
      end
      fds_pkg::OP_RINIT: begin
        x    <= ctl.sel ? sum_g : sum_c;
        r    <= '0;
        bitv <= SQW'(1) << (SQW - 2);
      end
      fds_pkg::OP_RSTEP: begin
        if ({1'b0, x} >= trial) begin
          x <= x - trial[SQW-1:0];
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
      end
      fds_pkg::OP_RSAVE: begin
        if (ctl.sel) begin
          dg <= r[RW-1:0];
        end else begin
          dc <= r[RW-1:0];
        end
      end
      fds_pkg::OP_TADD: begin
        if (tsum[fds_pkg::STRESS_W]) begin
          stress <= '1;
          sat    <= 1'b1;
        end else begin
          stress <= tsum[fds_pkg::STRESS_W-1:0];
        end
      end
      fds_pkg::OP_EMIT: begin
        result.stress      <= stress;
        result.agent_count <= fds_pkg::AGENT_COUNT_W'(n);
        result.saturated   <= sat | ctl.ovf;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/fds_ctrl.sv
// Controller: load bookkeeping, scaling sweep, pair walk and result handshake.
module fds_ctrl #(
  parameter int MAX_AGENTS = fds_pkg::MAX_AGENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_last,
  output logic                            item_ready,
  output logic                            result_valid,
  input  logic                            result_ready,
  output fds_pkg::ctrl_t                  ctl,
  output logic [$clog2(MAX_AGENTS)-1:0]   raw_waddr,
  output logic [$clog2(MAX_AGENTS)-1:0]   raw_raddr,
  output logic [$clog2(MAX_AGENTS)-1:0]   scl_waddr,
  output logic [$clog2(MAX_AGENTS)-1:0]   scl_raddr,
  output logic [$clog2(MAX_AGENTS+1)-1:0] n
);

  localparam int AW = $clog2(MAX_AGENTS);
  localparam int CW = $clog2(MAX_AGENTS+1);

  typedef enum logic [3:0] {
    S_IDLE, S_SC_RD, S_SC_MUL, S_SC_CLAMP, S_SC_WR, S_PR_RDA, S_PR_RDB, S_PR_LATB,
    S_SQ_MUL, S_SQ_ACC, S_RT_INIT, S_RT_STEP, S_RT_SAVE, S_T_MUL, S_T_ADD, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] count, e, i, j;
  logic [2:0] k;
  logic [4:0] step;
  logic sel, ovf, ovf_hold;
  logic accept, room, emit;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign room       = count < CW'(MAX_AGENTS);
  assign emit       = (state == S_DONE) && (!result_valid || result_ready);

  assign raw_waddr = count[AW-1:0];
  assign raw_raddr = e[AW-1:0];
  assign scl_waddr = e[AW-1:0];
  assign scl_raddr = (state == S_PR_RDA) ? i[AW-1:0] : j[AW-1:0];

  always_comb begin
    ctl.coord = k;
    ctl.sel   = sel;
    ctl.store = accept && room;
    ctl.ovf   = ovf_hold;
    case (state)
      S_IDLE:     ctl.op = (accept && item_last) ? fds_pkg::OP_START : fds_pkg::OP_NONE;
      S_SC_MUL:   ctl.op = fds_pkg::OP_SMUL;
      S_SC_CLAMP: ctl.op = fds_pkg::OP_SCLAMP;
      S_SC_WR:    ctl.op = fds_pkg::OP_SWRITE;
      S_PR_RDB:   ctl.op = fds_pkg::OP_LATA;
      S_PR_LATB:  ctl.op = fds_pkg::OP_LATB;
      S_SQ_MUL:   ctl.op = fds_pkg::OP_QMUL;
      S_SQ_ACC:   ctl.op = fds_pkg::OP_QACC;
      S_RT_INIT:  ctl.op = fds_pkg::OP_RINIT;
      S_RT_STEP:  ctl.op = fds_pkg::OP_RSTEP;
      S_RT_SAVE:  ctl.op = fds_pkg::OP_RSAVE;
      S_T_MUL:    ctl.op = fds_pkg::OP_TMUL;
      S_T_ADD:    ctl.op = fds_pkg::OP_TADD;
      S_DONE:     ctl.op = emit ? fds_pkg::OP_EMIT : fds_pkg::OP_NONE;
      default:    ctl.op = fds_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      ovf          <= 1'b0;
      ovf_hold     <= 1'b0;
      n            <= '0;
      e            <= '0;
      i            <= '0;
      j            <= '0;
      k            <= '0;
      step         <= '0;
      sel          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item_last) begin
              n        <= room ? count + CW'(1) : count;
              ovf_hold <= ovf || !room;
              count    <= '0;
              ovf      <= 1'b0;
              e        <= '0;
              k        <= '0;
              state    <= S_SC_RD;
            end else if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_SC_RD: state <= S_SC_MUL;
        S_SC_MUL: state <= S_SC_CLAMP;
        S_SC_CLAMP: begin
          if (k == 3'd5) begin
            state <= S_SC_WR;
          end else begin
            k     <= k + 3'd1;
            state <= S_SC_MUL;
          end
        end
        S_SC_WR: begin
          k <= '0;
          if (e == n - CW'(1)) begin
            i     <= '0;
            j     <= '0;
            state <= S_PR_RDA;
          end else begin
            e     <= e + CW'(1);
            state <= S_SC_RD;
          end
        end
        S_PR_RDA: state <= S_PR_RDB;
        S_PR_RDB: state <= S_PR_LATB;
        S_PR_LATB: begin
          k     <= '0;
          state <= S_SQ_MUL;
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (k == 3'd5) begin
            sel   <= 1'b0;
            state <= S_RT_INIT;
          end else begin
            k     <= k + 3'd1;
            state <= S_SQ_MUL;
          end
        end
        S_RT_INIT: begin
          step  <= '0;
          state <= S_RT_STEP;
        end
        S_RT_STEP: begin
          if (step == 5'(fds_pkg::SQRT_STEPS - 1)) begin
            state <= S_RT_SAVE;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_RT_SAVE: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_RT_INIT;
          end else begin
            state <= S_T_MUL;
          end
        end
        S_T_MUL: state <= S_T_ADD;
        S_T_ADD: begin
          if (j == n - CW'(1)) begin
            j <= '0;
            if (i == n - CW'(1)) begin
              state <= S_DONE;
            end else begin
              i     <= i + CW'(1);
              state <= S_PR_RDA;
            end
          end else begin
            j     <= j + CW'(1);
            state <= S_PR_RDA;
          end
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/formation_distance_stress.sv
// Top level of the formation distance stress block: configuration port and core wiring.
//
// The item channel (item_valid, item_ready, item) loads one agent per transaction:
// its current position and its assigned goal position. Each load is written to the
// agent store; agents beyond MAX_AGENTS are dropped and flagged.
// A transaction with last set closes the set and starts the evaluation, which
// uses the inv_scale value present at that moment.
// The evaluation first scales every stored coordinate into Q16.8 (one shared multiplier),
// then walks all ordered agent pairs. Each pair needs reads of both agents from the
// scaled store, six squared differences on the shared multiplier, and two 26-step
// square roots on one shared root unit.
// The result channel (result_valid, result_ready, result) carries one transaction per
// set. The result sits in an output register; the block accepts further loads while it
// waits, and only a following evaluation holds at its end until the receiver takes it.
// Item loads are refused during an evaluation.
// Reset (rst, synchronous) empties the current set, drops any pending result and
// sets inv_scale to 1.0. The APB-style port holds inv_scale at address 0.
module formation_distance_stress #(
  parameter int MAX_AGENTS = fds_pkg::MAX_AGENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  fds_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output fds_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fds_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(MAX_AGENTS);
  localparam int CW = $clog2(MAX_AGENTS+1);

  logic [fds_pkg::SCALE_W-1:0] inv_scale;
  fds_pkg::ctrl_t ctl;
  logic [AW-1:0] raw_waddr, raw_raddr, scl_waddr, scl_raddr;
  logic [CW-1:0] n;

  // The single register decodes on the word address; writes above it are ignored.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {8'd0, inv_scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale <= fds_pkg::INV_SCALE_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      inv_scale <= pwdata[fds_pkg::SCALE_W-1:0];
    end
  end

  fds_ctrl #(.MAX_AGENTS(MAX_AGENTS)) u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_last(item.last), .item_ready(item_ready),
    .result_valid(result_valid), .result_ready(result_ready),
    .ctl(ctl),
    .raw_waddr(raw_waddr), .raw_raddr(raw_raddr),
    .scl_waddr(scl_waddr), .scl_raddr(scl_raddr),
    .n(n)
  );

  fds_dp #(.MAX_AGENTS(MAX_AGENTS)) u_dp (
    .clk(clk), .item(item), .inv_scale(inv_scale), .ctl(ctl),
    .raw_waddr(raw_waddr), .raw_raddr(raw_raddr),
    .scl_waddr(scl_waddr), .scl_raddr(scl_raddr),
    .n(n), .result(result)
  );

endmodule

>>> bench/tb_formation_distance_stress.sv
// Self-checking testbench for the formation distance stress block.
module tb_formation_distance_stress;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = fds_pkg::COORD_W;
  localparam int SCALE_W = fds_pkg::SCALE_W;
  localparam int STRESS_W = fds_pkg::STRESS_W;
  localparam int AGENT_COUNT_W = fds_pkg::AGENT_COUNT_W;
  localparam int PADDR_W = fds_pkg::PADDR_W;
  localparam logic [SCALE_W-1:0] INV_SCALE_RESET = fds_pkg::INV_SCALE_RESET;
  typedef fds_pkg::item_t item_t;
  typedef fds_pkg::result_t result_t;

  localparam int AGENT_LIMIT = fds_pkg::MAX_AGENTS_DEF;
  localparam logic [PADDR_W-1:0] ADDR_INV_SCALE = '0;
  localparam longint unsigned STRESS_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint COORD_TOP = 64'sd16777215;
  localparam longint COORD_BOTTOM = -64'sd16777216;

  // The scoreboard keeps its own copy of the agent set and of inv_scale. It
  // predicts a result whenever a transaction with last set is accepted and
  // compares each result transaction against the oldest prediction.
  class stress_scoreboard;
    longint pos_set[AGENT_LIMIT][3];
    longint goal_set[AGENT_LIMIT][3];
    int unsigned agents_held;
    bit dropped_agent;
    bit clamp_seen;
    logic [SCALE_W-1:0] inv_scale;
    result_t stress_queue[$];
    int unsigned errors;

    function void clear_set();
      agents_held = 0;
      dropped_agent = 0;
      inv_scale = INV_SCALE_RESET;
      stress_queue.delete();
      errors = 0;
    endfunction

    function longint scaled(longint raw);
      longint prod;
      longint q;
      prod = raw * longint'(inv_scale);
      q = prod >>> 8;  // floor division by 256
      if (q > COORD_TOP) begin
        clamp_seen = 1;
        return COORD_TOP;
      end
      if (q < COORD_BOTTOM) begin
        clamp_seen = 1;
        return COORD_BOTTOM;
      end
      return q;
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned span(longint a0, longint a1, longint a2,
                                   longint b0, longint b1, longint b2);
      longint unsigned s;
      s = longint'(a0 - b0) * longint'(a0 - b0);
      s += longint'(a1 - b1) * longint'(a1 - b1);
      s += longint'(a2 - b2) * longint'(a2 - b2);
      return root_floor(s);
    endfunction

    // Notes one accepted item transaction.
    function void note_item(item_t it);
      longint sp[AGENT_LIMIT][3];
      longint sg[AGENT_LIMIT][3];
      longint unsigned total;
      longint unsigned dc;
      longint unsigned dg;
      longint unsigned gap;
      longint unsigned term;
      result_t r;
      if (agents_held < AGENT_LIMIT) begin
        pos_set[agents_held][0] = longint'(it.pos_x);
        pos_set[agents_held][1] = longint'(it.pos_y);
        pos_set[agents_held][2] = longint'(it.pos_z);
        goal_set[agents_held][0] = longint'(it.goal_x);
        goal_set[agents_held][1] = longint'(it.goal_y);
        goal_set[agents_held][2] = longint'(it.goal_z);
        agents_held++;
      end else begin
        dropped_agent = 1;
      end
      if (!it.last) return;
      clamp_seen = dropped_agent;
      for (int i = 0; i < agents_held; i++)
        for (int k = 0; k < 3; k++) begin
          sp[i][k] = scaled(pos_set[i][k]);
          sg[i][k] = scaled(goal_set[i][k]);
        end
      total = 0;
      for (int i = 0; i < agents_held; i++)
        for (int j = 0; j < agents_held; j++) begin
          dc = span(sp[i][0], sp[i][1], sp[i][2], sp[j][0], sp[j][1], sp[j][2]);
          dg = span(sg[i][0], sg[i][1], sg[i][2], sg[j][0], sg[j][1], sg[j][2]);
          gap = (dc > dg) ? dc - dg : dg - dc;
          term = gap * gap;
          if (term > STRESS_TOP - total) begin
            total = STRESS_TOP;
            clamp_seen = 1;
          end else begin
            total += term;
          end
        end
      r.stress = total[STRESS_W-1:0];
      r.agent_count = agents_held[AGENT_COUNT_W-1:0];
      r.saturated = clamp_seen;
      stress_queue = {stress_queue, r};
      agents_held = 0;
      dropped_agent = 0;
    endfunction

    // Checks one accepted result transaction against the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (stress_queue.size() == 0) begin
        $display("%0t: unexpected result: stress=%0d count=%0d sat=%0b", $time,
                 got.stress, got.agent_count, got.saturated);
        errors++;
        return;
      end
      want = stress_queue.pop_front();
      if (got.stress !== want.stress) begin
        $display("%0t: stress mismatch: expected %0d, actual %0d", $time,
                 want.stress, got.stress);
        errors++;
      end
      if (got.agent_count !== want.agent_count) begin
        $display("%0t: agent_count mismatch: expected %0d, actual %0d", $time,
                 want.agent_count, got.agent_count);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b", $time,
                 want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stress_scoreboard sb = new();

  // Idling is switched off for the last part of the run. A long receiver
  // hold-off is requested by the stimulus and counted by the receiver.
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  formation_distance_stress i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Generous limit: small sets dominate, but a few sets of full size and the long
  // hold-off also run.
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

  // Result monitor: sample the handshake at the rising edge.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_ready = 1'b0;
        repeat (4000) @(negedge clk);
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        result_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 6) - 1;
        result_ready = 1'b0;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // Writes a register through the APB-style port while the block is idle.
  task automatic write_scale(logic [SCALE_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_INV_SCALE;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.inv_scale = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Offers one item transaction, with an optional random gap before it.
  task automatic send_item(item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Waits until every predicted result has arrived, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.stress_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom_range(0, 24'hFFFFFF));
      1: return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
      2: return COORD_W'(int'($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic item_t pick_item(logic is_last);
    item_t it;
    it.pos_x = pick_coord();
    it.pos_y = pick_coord();
    it.pos_z = pick_coord();
    it.goal_x = pick_coord();
    it.goal_y = pick_coord();
    it.goal_z = pick_coord();
    it.last = is_last;
    return it;
  endfunction

  function automatic item_t flat_item(logic [COORD_W-1:0] p, logic [COORD_W-1:0] g,
                                      logic is_last);
    item_t it;
    it = {p, p, p, g, g, g, is_last};
    return it;
  endfunction

  // Sends one set of random agents, the final one flagged last.
  task automatic send_set(int unsigned agents);
    for (int unsigned a = 1; a <= agents; a++) send_item(pick_item(a == agents));
  endtask

  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 8);
    if (r < 98) return AGENT_LIMIT;
    return $urandom_range(AGENT_LIMIT + 1, AGENT_LIMIT + 2);
  endfunction

  initial begin
    logic [SCALE_W-1:0] scales[6];
    int unsigned sent;
    int unsigned n;
    sb.clear_set();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: a single agent, coordinate extremes, equal distances,
    // an agent with last clear followed by the closing one, and zero, full and smallest nonzero scale.
    send_item(flat_item(24'h7FFFFF, 24'h800000, 1'b1));
    send_item(flat_item(24'h7FFFFF, 24'h000000, 1'b0));
    send_item(flat_item(24'h800000, 24'h000000, 1'b1));
    send_item(flat_item(24'h000010, 24'h000100, 1'b0));
    send_item(flat_item(24'hFFFFF0, 24'hFFFF00, 1'b1));
    send_item(flat_item(24'h000005, 24'h000005, 1'b0));
    send_item(flat_item(24'h000009, 24'h000009, 1'b1));
    send_item(flat_item(24'h000001, 24'hFFFFFF, 1'b0));
    send_item(flat_item(24'h000002, 24'hFFFFFE, 1'b0));
    send_item(flat_item(24'h000003, 24'h7FFFFF, 1'b1));
    drain();
    write_scale(24'd0);
    send_item(flat_item(24'h123456, 24'h800000, 1'b0));
    send_item(flat_item(24'h7FFFFF, 24'h000001, 1'b1));
    drain();
    write_scale(24'hFFFFFF);
    send_item(flat_item(24'h000001, 24'hFFFFFF, 1'b0));
    send_item(flat_item(24'h000100, 24'h000200, 1'b1));
    drain();
    write_scale(24'd1);
    send_item(flat_item(24'h7FFFFF, 24'h800000, 1'b0));
    send_item(flat_item(24'h800000, 24'h7FFFFF, 1'b1));
    drain();

    // Long receiver hold-off while small sets keep coming, so that a second
    // evaluation completes behind the held result and loads are refused.
    write_scale(INV_SCALE_RESET);
    hold_request = 1'b1;
    for (int s = 0; s < 6; s++) send_set(2);
    drain();

    // Random part, in phases with different scale settings.
    scales[0] = INV_SCALE_RESET;
    scales[1] = 24'd256;
    scales[2] = 24'hFFFFFF;
    scales[3] = 24'd1;
    scales[4] = 24'd0;
    scales[5] = SCALE_W'($urandom_range(1, 24'hFFFFFF));
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_scale(scales[ph]);
      if (ph == 5) idle_on = 1'b0;
      while (sent < (ph + 1) * 160) begin
        n = pick_set_size();
        send_set(n);
        sent += n;
      end
      drain();
    end

    if (sb.errors == 0 && sb.stress_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/fds_pkg.sv
rtl/core/fds_ram.sv
rtl/core/fds_dp.sv
rtl/core/fds_ctrl.sv
rtl/core/formation_distance_stress.sv
bench/tb_formation_distance_stress.sv
